### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the LZW encoder modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define LZWE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LZWE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LZWE_ASSERT(lbl, prop, msg)
`define LZWE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/lzwe_pkg.sv
// ---------------------------------------------------------------------------
// lzwe_pkg
// Types and constants of the LZW encoder.
// ---------------------------------------------------------------------------
package lzwe_pkg;

    localparam int CODE_BITS_DEF = 12;
    localparam int OUT_CODE_W    = 12;
    localparam int FIRST_FREE    = 256;
    localparam int EPOCH_W       = 8;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] code;
        logic                  last;
    } t_out_item;

    // first byte of a message starts the prefix; any other byte extends it
    typedef enum logic {
        K_FIRST,
        K_EXTEND
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_q_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CMP,
        S_EMIT_MISS,
        S_EMIT_LAST
    } t_back_state;

endpackage

### hdl/lzwe_front.sv
// ---------------------------------------------------------------------------
// lzwe_front
// Accepts bytes, tags message starts and queues them for the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lzwe_pkg::t_in_item i_data,
    output logic              o_stall,
    output logic              o_q_valid,
    output lzwe_pkg::t_q_item o_q_item,
    input  logic              i_q_pop
);
    import lzwe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_q_item            r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               r_first;
    logic               accept;
    logic               pop;

    assign o_stall   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign accept    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rd_ptr];
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr].kind           <= r_first ? K_FIRST : K_EXTEND;
            r_q[r_wr_ptr].data_byte      <= i_data.data_byte;
            r_q[r_wr_ptr].end_of_message <= i_data.end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_first  <= 1'b1;
        end else begin
            if (accept) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                r_first  <= i_data.end_of_message;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(accept) - CNT_W'(pop);
        end
    end

    `LZWE_ASSERT(a_cnt_range, r_count <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
    `LZWE_ASSERT(a_pop_nonempty, i_q_pop |-> o_q_valid, "pop from empty queue")
    `LZWE_ASSERT(a_eom_first, (accept && i_data.end_of_message) |=> r_first,
                 "no message start after end of message")

endmodule

### hdl/lzwe_back.sv
// ---------------------------------------------------------------------------
// lzwe_back
// Hashed dictionary search, insertion and code emission.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwe_back #(
    parameter int CODE_BITS = lzwe_pkg::CODE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  lzwe_pkg::t_q_item   i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    output lzwe_pkg::t_out_item o_data,
    input  logic                i_stall
);
    import lzwe_pkg::*;

    localparam int SLOTS = 1 << CODE_BITS;

    // slot: message tag (0 = empty), key (prefix, byte), assigned code
    typedef struct packed {
        logic [EPOCH_W-1:0]   epoch;
        logic [CODE_BITS-1:0] pre;
        logic [7:0]           byt;
        logic [CODE_BITS-1:0] code;
    } t_slot;

    t_slot                r_mem [SLOTS];
    t_slot                r_rd;
    t_back_state          r_state, n_state;
    logic [CODE_BITS-1:0] r_addr, n_addr;
    logic [CODE_BITS-1:0] r_clr, n_clr;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [CODE_BITS:0]   r_next_free, n_next_free;
    logic [CODE_BITS-1:0] r_prefix, n_prefix;
    logic [CODE_BITS-1:0] r_emit, n_emit;
    logic [7:0]           r_byte, n_byte;
    logic                 r_eom, n_eom;
    logic                 r_out_valid;
    t_out_item            r_out;
    logic                 out_free, out_load;
    t_out_item            out_item;
    logic                 wr_en;
    logic [CODE_BITS-1:0] wr_addr;
    t_slot                wr_word;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        r_rd <= r_mem[r_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_clr       = r_clr;
        n_epoch     = r_epoch;
        n_next_free = r_next_free;
        n_prefix    = r_prefix;
        n_emit      = r_emit;
        n_byte      = r_byte;
        n_eom       = r_eom;
        o_q_pop     = 1'b0;
        out_load    = 1'b0;
        out_item    = '0;
        wr_en       = 1'b0;
        wr_addr     = r_addr;
        wr_word     = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) begin
                    n_epoch = EPOCH_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_byte  = i_q_item.data_byte;
                    n_eom   = i_q_item.end_of_message;
                    if (i_q_item.kind == K_FIRST) begin
                        n_prefix = CODE_BITS'(i_q_item.data_byte);
                        n_state  = i_q_item.end_of_message ? S_EMIT_LAST : S_IDLE;
                    end else begin
                        n_addr  = r_prefix ^ (CODE_BITS'(i_q_item.data_byte) << (CODE_BITS - 8));
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd.epoch == r_epoch) begin
                    if (r_rd.pre == r_prefix && r_rd.byt == r_byte) begin
                        n_prefix = r_rd.code;
                        n_state  = r_eom ? S_EMIT_LAST : S_IDLE;
                    end else begin
                        // collision: linear probe
                        n_addr  = r_addr + 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    n_emit   = r_prefix;
                    n_prefix = CODE_BITS'(r_byte);
                    if (!r_next_free[CODE_BITS]) begin
                        wr_en       = 1'b1;
                        wr_word     = '{r_epoch, r_prefix, r_byte, r_next_free[CODE_BITS-1:0]};
                        n_next_free = r_next_free + 1'b1;
                    end
                    n_state = S_EMIT_MISS;
                end
            end
            S_EMIT_MISS: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_item = '{OUT_CODE_W'(r_emit), 1'b0};
                    n_state  = r_eom ? S_EMIT_LAST : S_IDLE;
                end
            end
            S_EMIT_LAST: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_item    = '{OUT_CODE_W'(r_prefix), 1'b1};
                    n_next_free = (CODE_BITS + 1)'(FIRST_FREE);
                    n_prefix    = '0;
                    n_epoch     = r_epoch + 1'b1;
                    // tag wrap: stale slots must be swept before reuse
                    n_state     = (n_epoch == '0) ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_epoch     <= '0;
            r_next_free <= (CODE_BITS + 1)'(FIRST_FREE);
            r_prefix    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_epoch     <= n_epoch;
            r_next_free <= n_next_free;
            r_prefix    <= n_prefix;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_emit <= n_emit;
        r_byte <= n_byte;
        r_eom  <= n_eom;
        if (out_load) begin
            r_out <= out_item;
        end
    end

    `LZWE_ASSERT(a_free_range, r_next_free <= (CODE_BITS + 1)'(SLOTS),
                 "next free code beyond code space")
    `LZWE_ASSERT(a_clear_quiet, (r_state == S_CLEAR) |-> (!out_load && !o_q_pop),
                 "activity during clearing pass")
    `LZWE_ASSERT(a_end_resets, (r_state == S_EMIT_LAST && out_free) |=>
                 (r_next_free == (CODE_BITS + 1)'(FIRST_FREE)),
                 "dictionary not reset after message")

endmodule

### hdl/lzw_encoder_core.sv
// ---------------------------------------------------------------------------
// lzw_encoder_core
// LZW encoder: bytes in, CODE_BITS-wide dictionary, 12-bit codes out.
// ---------------------------------------------------------------------------
// A byte that starts a message only sets the new prefix in the back end; any
// other byte needs a hashed lookup in the dictionary memory (address, read,
// compare), repeated for each extra linear probe on a collision; a miss, and
// the end of a message, emits a code once the output is free. After reset, and
// after every 255 messages, a clearing pass over all 2**CODE_BITS slots
// sweeps the memory; bytes are queued but not processed meanwhile.
module lzw_encoder_core #(
    parameter int CODE_BITS = lzwe_pkg::CODE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lzwe_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output lzwe_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import lzwe_pkg::*;

    logic    q_valid;
    t_q_item q_item;
    logic    q_pop;

    lzwe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_stall   (o_in_stall),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    lzwe_back #(
        .CODE_BITS (CODE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .o_data    (o_out_data),
        .i_stall   (i_out_stall)
    );

endmodule
